>>> design/ter_pkg.sv
package ter_pkg;

   // Field widths
   localparam int COORD_W  = 10;
   localparam int BRIGHT_W = 8;
   localparam int TILE_W   = 4;
   localparam int PIX_W    = 7;
   localparam int BAND_W   = 2;

   // Datapath widths
   localparam int DIFF_W   = COORD_W + 1;   // vertex difference
   localparam int BOX_W    = 12;            // bounding box compares, signed
   localparam int OPB_W    = 12;            // narrow multiplier operand
   localparam int EDGE_W   = 24;            // edge values and area
   localparam int NUM_W    = 34;            // weighted numerator, thresholds
   localparam int PROD_W   = EDGE_W + OPB_W;
   localparam int MUL_OP_W = 5;

   // Shade thresholds as multiples of the area
   localparam int SHADE_LO_MUL = 85;
   localparam int SHADE_HI_MUL = 170;

   localparam logic [BAND_W-1:0] BAND_LOW  = 2'd1;
   localparam logic [BAND_W-1:0] BAND_MID  = 2'd2;
   localparam logic [BAND_W-1:0] BAND_HIGH = 2'd3;

   // Edge k runs from vertex EDGE_A[k] to vertex EDGE_B[k]
   localparam int EDGE_A [3] = '{1, 2, 0};
   localparam int EDGE_B [3] = '{2, 0, 1};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_AREA_WB,
      ST_SETUP,
      ST_EDGE,
      ST_EDGE_WB,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Multiply sequence, issued in this order
   typedef enum logic [MUL_OP_W-1:0] {
      MUL_AREA_A,
      MUL_AREA_B,
      MUL_E0Y,
      MUL_E0X,
      MUL_E1Y,
      MUL_E1X,
      MUL_E2Y,
      MUL_E2X,
      MUL_NX0,
      MUL_NX1,
      MUL_NX2,
      MUL_NY0,
      MUL_NY1,
      MUL_NY2,
      MUL_N0,
      MUL_N1,
      MUL_N2
   } mul_op_type;

   typedef struct packed {
      logic       req_ready;
      logic       load;
      logic       mul_go;
      mul_op_type mul_op;
      logic       setup;
      logic       scan_step;
      logic       capture;
      logic       push;
      logic       flush;
   } ter_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic area_zero;
      logic win_empty;
      logic covered;
      logic pend_valid;
      logic out_free;
      logic at_last;
   } ter_status_type;

endpackage

>>> design/ter_ifc.sv
interface ter_req_if;
   import ter_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  vert0_x;
   logic signed [COORD_W-1:0]  vert0_y;
   logic        [BRIGHT_W-1:0] vert0_bright;
   logic signed [COORD_W-1:0]  vert1_x;
   logic signed [COORD_W-1:0]  vert1_y;
   logic        [BRIGHT_W-1:0] vert1_bright;
   logic signed [COORD_W-1:0]  vert2_x;
   logic signed [COORD_W-1:0]  vert2_y;
   logic        [BRIGHT_W-1:0] vert2_bright;
   logic        [TILE_W-1:0]   tile_col;
   logic        [TILE_W-1:0]   tile_row;

   modport source (
      output valid, vert0_x, vert0_y, vert0_bright, vert1_x, vert1_y, vert1_bright,
             vert2_x, vert2_y, vert2_bright, tile_col, tile_row,
      input  ready
   );

   modport sink (
      input  valid, vert0_x, vert0_y, vert0_bright, vert1_x, vert1_y, vert1_bright,
             vert2_x, vert2_y, vert2_bright, tile_col, tile_row,
      output ready
   );
endinterface

interface ter_rsp_if;
   import ter_pkg::*;

   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  pixel_x;
   logic [PIX_W-1:0]  pixel_y;
   logic [BAND_W-1:0] shade_band;
   logic              last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, shade_band, last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, shade_band, last_pixel,
      output ready
   );
endinterface

>>> design/ter_ctrl.sv
module ter_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ter_pkg::ter_status_type status,
   output ter_pkg::ter_cmd_type    cmd
);
   import ter_pkg::*;

   state_type  state_ff, state_in;
   mul_op_type op_ff, op_in;
   logic       advance;

   // a covered pixel can only move on once the held one has somewhere to go
   assign advance = !status.covered || !status.pend_valid || status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= MUL_AREA_A;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin : next_state
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               state_in = ST_AREA;
               op_in    = MUL_AREA_A;
            end
         end
         ST_AREA: begin
            if (op_ff == MUL_AREA_B) begin
               state_in = ST_AREA_WB;
            end else begin
               op_in = mul_op_type'(MUL_OP_W'(op_ff) + MUL_OP_W'(1));
            end
         end
         ST_AREA_WB: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (status.area_zero || status.win_empty) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EDGE;
               op_in    = MUL_E0Y;
            end
         end
         ST_EDGE: begin
            if (op_ff == MUL_N2) begin
               state_in = ST_EDGE_WB;
            end else begin
               op_in = mul_op_type'(MUL_OP_W'(op_ff) + MUL_OP_W'(1));
            end
         end
         ST_EDGE_WB: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (advance && status.at_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin : outputs
      cmd = '0;
      cmd.mul_op = op_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load      = status.req_valid;
         end
         ST_AREA: begin
            cmd.mul_go = 1'b1;
         end
         ST_SETUP: begin
            cmd.setup = !(status.area_zero || status.win_empty);
         end
         ST_EDGE: begin
            cmd.mul_go = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = advance;
            cmd.capture   = advance && status.covered;
            cmd.push      = advance && status.covered && status.pend_valid;
         end
         ST_FLUSH: begin
            cmd.flush = status.pend_valid && status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> design/ter_datapath.sv
module ter_datapath #(
   parameter int CANVAS_WIDTH  = 128,
   parameter int CANVAS_HEIGHT = 128,
   parameter int TILE_SIZE     = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ter_pkg::ter_cmd_type    cmd,
   output ter_pkg::ter_status_type status,
   ter_req_if.sink                 req_if,
   ter_rsp_if.source               rsp_if
);
   import ter_pkg::*;

   // triangle, after the swap once set up
   logic signed [COORD_W-1:0]  vx_ff [3];
   logic signed [COORD_W-1:0]  vy_ff [3];
   logic        [BRIGHT_W-1:0] vb_ff [3];
   logic        [TILE_W-1:0]   tc_ff, tr_ff;

   logic signed [DIFF_W-1:0]   dx_ff [3];   // edge step per pixel in x
   logic signed [DIFF_W-1:0]   dy_ff [3];   // edge step per row
   logic        [PIX_W-1:0]    lox_ff, hix_ff, loy_ff, hiy_ff;
   logic        [PIX_W-1:0]    px_ff, px_in, py_ff, py_in;

   logic signed [EDGE_W-1:0]   area_ff, area_in;
   logic signed [NUM_W-1:0]    th1_ff, th2_ff;

   // shared multiplier
   logic signed [EDGE_W-1:0]   op_a;
   logic signed [OPB_W-1:0]    op_b;
   logic signed [PROD_W-1:0]   p_ff;
   mul_op_type                 tag_ff;
   logic                       pv_ff;

   // incremental edge and numerator values
   logic signed [EDGE_W-1:0]   e_ff [3];
   logic signed [EDGE_W-1:0]   e_in [3];
   logic signed [EDGE_W-1:0]   erow_ff [3];
   logic signed [EDGE_W-1:0]   erow_in [3];
   logic signed [NUM_W-1:0]    num_ff, num_in, nrow_ff, nrow_in;
   logic signed [NUM_W-1:0]    nx_ff, nx_in, ny_ff, ny_in;

   // one covered pixel held back until the next one or the end of the scan
   logic                       pend_valid_ff, pend_valid_in;
   logic        [PIX_W-1:0]    pend_x_ff, pend_y_ff;
   logic        [BAND_W-1:0]   pend_band_ff;

   logic                       out_valid_ff, out_valid_in;
   logic        [PIX_W-1:0]    out_x_ff, out_y_ff;
   logic        [BAND_W-1:0]   out_band_ff;
   logic                       out_last_ff;

   logic                       load;
   logic signed [PROD_W-1:0]   p_in;
   logic signed [EDGE_W-1:0]   p_edge;
   logic signed [NUM_W-1:0]    p_num;
   logic                       area_neg;
   logic signed [EDGE_W-1:0]   abs_area;
   logic signed [COORD_W-1:0]  sx [3];
   logic signed [COORD_W-1:0]  sy [3];
   logic        [BRIGHT_W-1:0] sb [3];
   logic signed [COORD_W-1:0]  minx, maxx, miny, maxy;
   logic signed [BOX_W-1:0]    tx0, ty0, lox, hix, loy, hiy;
   logic signed [OPB_W-1:0]    lox_ext, loy_ext;
   logic signed [OPB_W-1:0]    xrel [3];
   logic signed [OPB_W-1:0]    yrel [3];
   logic signed [OPB_W-1:0]    bw [3];
   logic                       covered;
   logic        [BAND_W-1:0]   band;
   logic                       out_free;

   function automatic logic signed [COORD_W-1:0] min3(
      input logic signed [COORD_W-1:0] a, b, c);
      logic signed [COORD_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(
      input logic signed [COORD_W-1:0] a, b, c);
      logic signed [COORD_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   assign load          = cmd.load;
   assign req_if.ready  = cmd.req_ready;
   assign out_free      = !out_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.pixel_x    = out_x_ff;
   assign rsp_if.pixel_y    = out_y_ff;
   assign rsp_if.shade_band = out_band_ff;
   assign rsp_if.last_pixel = out_last_ff;

   // setup: orientation swap and window bounds
   assign area_neg = area_ff[EDGE_W-1];
   assign abs_area = area_neg ? -area_ff : area_ff;

   always_comb begin : swap
      sx[0] = vx_ff[0];
      sy[0] = vy_ff[0];
      sb[0] = vb_ff[0];
      sx[1] = area_neg ? vx_ff[2] : vx_ff[1];
      sy[1] = area_neg ? vy_ff[2] : vy_ff[1];
      sb[1] = area_neg ? vb_ff[2] : vb_ff[1];
      sx[2] = area_neg ? vx_ff[1] : vx_ff[2];
      sy[2] = area_neg ? vy_ff[1] : vy_ff[2];
      sb[2] = area_neg ? vb_ff[1] : vb_ff[2];
   end

   always_comb begin : window
      minx = min3(vx_ff[0], vx_ff[1], vx_ff[2]);
      maxx = max3(vx_ff[0], vx_ff[1], vx_ff[2]);
      miny = min3(vy_ff[0], vy_ff[1], vy_ff[2]);
      maxy = max3(vy_ff[0], vy_ff[1], vy_ff[2]);
      tx0  = $signed(BOX_W'(tc_ff) * BOX_W'(TILE_SIZE));
      ty0  = $signed(BOX_W'(tr_ff) * BOX_W'(TILE_SIZE));
      // tile origin is never negative, so it also covers the canvas low edge
      lox  = (BOX_W'(minx) > tx0) ? BOX_W'(minx) : tx0;
      loy  = (BOX_W'(miny) > ty0) ? BOX_W'(miny) : ty0;
      hix  = BOX_W'(maxx);
      if (hix > BOX_W'(CANVAS_WIDTH - 1)) begin
         hix = BOX_W'(CANVAS_WIDTH - 1);
      end
      if (hix > tx0 + BOX_W'(TILE_SIZE - 1)) begin
         hix = tx0 + BOX_W'(TILE_SIZE - 1);
      end
      hiy  = BOX_W'(maxy);
      if (hiy > BOX_W'(CANVAS_HEIGHT - 1)) begin
         hiy = BOX_W'(CANVAS_HEIGHT - 1);
      end
      if (hiy > ty0 + BOX_W'(TILE_SIZE - 1)) begin
         hiy = ty0 + BOX_W'(TILE_SIZE - 1);
      end
   end

   // multiplier operands
   assign lox_ext = $signed({{(OPB_W-PIX_W){1'b0}}, lox_ff});
   assign loy_ext = $signed({{(OPB_W-PIX_W){1'b0}}, loy_ff});

   always_comb begin : rel_terms
      for (int k = 0; k < 3; k++) begin
         xrel[k] = lox_ext - OPB_W'(vx_ff[EDGE_A[k]]);
         yrel[k] = loy_ext - OPB_W'(vy_ff[EDGE_A[k]]);
         bw[k]   = $signed({{(OPB_W-BRIGHT_W){1'b0}}, vb_ff[k]});
      end
   end

   always_comb begin : mul_operands
      op_a = '0;
      op_b = '0;
      case (cmd.mul_op)
         MUL_AREA_A: begin
            op_a = EDGE_W'(DIFF_W'(vx_ff[1]) - DIFF_W'(vx_ff[0]));
            op_b = OPB_W'(DIFF_W'(vy_ff[2]) - DIFF_W'(vy_ff[0]));
         end
         MUL_AREA_B: begin
            op_a = EDGE_W'(DIFF_W'(vy_ff[1]) - DIFF_W'(vy_ff[0]));
            op_b = OPB_W'(DIFF_W'(vx_ff[2]) - DIFF_W'(vx_ff[0]));
         end
         MUL_E0Y: begin op_a = EDGE_W'(dy_ff[0]); op_b = yrel[0]; end
         MUL_E0X: begin op_a = EDGE_W'(dx_ff[0]); op_b = xrel[0]; end
         MUL_E1Y: begin op_a = EDGE_W'(dy_ff[1]); op_b = yrel[1]; end
         MUL_E1X: begin op_a = EDGE_W'(dx_ff[1]); op_b = xrel[1]; end
         MUL_E2Y: begin op_a = EDGE_W'(dy_ff[2]); op_b = yrel[2]; end
         MUL_E2X: begin op_a = EDGE_W'(dx_ff[2]); op_b = xrel[2]; end
         MUL_NX0: begin op_a = EDGE_W'(dx_ff[0]); op_b = bw[0]; end
         MUL_NX1: begin op_a = EDGE_W'(dx_ff[1]); op_b = bw[1]; end
         MUL_NX2: begin op_a = EDGE_W'(dx_ff[2]); op_b = bw[2]; end
         MUL_NY0: begin op_a = EDGE_W'(dy_ff[0]); op_b = bw[0]; end
         MUL_NY1: begin op_a = EDGE_W'(dy_ff[1]); op_b = bw[1]; end
         MUL_NY2: begin op_a = EDGE_W'(dy_ff[2]); op_b = bw[2]; end
         MUL_N0:  begin op_a = e_ff[0]; op_b = bw[0]; end
         MUL_N1:  begin op_a = e_ff[1]; op_b = bw[1]; end
         MUL_N2:  begin op_a = e_ff[2]; op_b = bw[2]; end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign p_in   = PROD_W'(op_a) * PROD_W'(op_b);
   assign p_edge = p_ff[EDGE_W-1:0];
   assign p_num  = p_ff[NUM_W-1:0];

   // pixel test and band
   assign covered = !e_ff[0][EDGE_W-1] && !e_ff[1][EDGE_W-1] && !e_ff[2][EDGE_W-1];
   assign band    = (num_ff < th1_ff) ? BAND_LOW :
                    (num_ff < th2_ff) ? BAND_MID : BAND_HIGH;

   always_comb begin : accumulate
      area_in = area_ff;
      e_in    = e_ff;
      erow_in = erow_ff;
      num_in  = num_ff;
      nrow_in = nrow_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      px_in   = px_ff;
      py_in   = py_ff;

      if (pv_ff) begin
         case (tag_ff)
            MUL_AREA_A: area_in = p_edge;
            MUL_AREA_B: area_in = area_ff - p_edge;
            MUL_E0Y:    e_in[0] = p_edge;
            MUL_E1Y:    e_in[1] = p_edge;
            MUL_E2Y:    e_in[2] = p_edge;
            MUL_E0X: begin
               e_in[0]    = e_ff[0] + p_edge;
               erow_in[0] = e_ff[0] + p_edge;
            end
            MUL_E1X: begin
               e_in[1]    = e_ff[1] + p_edge;
               erow_in[1] = e_ff[1] + p_edge;
            end
            MUL_E2X: begin
               e_in[2]    = e_ff[2] + p_edge;
               erow_in[2] = e_ff[2] + p_edge;
            end
            MUL_NX0:    nx_in = p_num;
            MUL_NX1,
            MUL_NX2:    nx_in = nx_ff + p_num;
            MUL_NY0:    ny_in = p_num;
            MUL_NY1,
            MUL_NY2:    ny_in = ny_ff + p_num;
            MUL_N0: begin
               num_in  = p_num;
               nrow_in = p_num;
            end
            MUL_N1,
            MUL_N2: begin
               num_in  = num_ff + p_num;
               nrow_in = num_ff + p_num;
            end
            default: begin
               area_in = area_ff;
            end
         endcase
      end

      if (cmd.setup) begin
         area_in = abs_area;
         px_in   = lox[PIX_W-1:0];
         py_in   = loy[PIX_W-1:0];
      end

      if (cmd.scan_step) begin
         if (px_ff == hix_ff) begin
            // wrap to the start of the next row
            px_in   = lox_ff;
            py_in   = py_ff + PIX_W'(1);
            for (int k = 0; k < 3; k++) begin
               e_in[k]    = erow_ff[k] + EDGE_W'(dy_ff[k]);
               erow_in[k] = erow_ff[k] + EDGE_W'(dy_ff[k]);
            end
            num_in  = nrow_ff + ny_ff;
            nrow_in = nrow_ff + ny_ff;
         end else begin
            px_in = px_ff + PIX_W'(1);
            for (int k = 0; k < 3; k++) begin
               e_in[k] = e_ff[k] + EDGE_W'(dx_ff[k]);
            end
            num_in = num_ff + nx_ff;
         end
      end
   end

   always_comb begin : handoff
      pend_valid_in = pend_valid_ff;
      if (cmd.capture) begin
         pend_valid_in = 1'b1;
      end else if (cmd.flush || cmd.load) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (cmd.push || cmd.flush) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pv_ff         <= cmd.mul_go;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vx_ff[0] <= req_if.vert0_x;
         vy_ff[0] <= req_if.vert0_y;
         vb_ff[0] <= req_if.vert0_bright;
         vx_ff[1] <= req_if.vert1_x;
         vy_ff[1] <= req_if.vert1_y;
         vb_ff[1] <= req_if.vert1_bright;
         vx_ff[2] <= req_if.vert2_x;
         vy_ff[2] <= req_if.vert2_y;
         vb_ff[2] <= req_if.vert2_bright;
         tc_ff    <= req_if.tile_col;
         tr_ff    <= req_if.tile_row;
      end
      if (cmd.setup) begin
         vx_ff  <= sx;
         vy_ff  <= sy;
         vb_ff  <= sb;
         for (int k = 0; k < 3; k++) begin
            dx_ff[k] <= DIFF_W'(sy[EDGE_A[k]]) - DIFF_W'(sy[EDGE_B[k]]);
            dy_ff[k] <= DIFF_W'(sx[EDGE_B[k]]) - DIFF_W'(sx[EDGE_A[k]]);
         end
         lox_ff <= lox[PIX_W-1:0];
         hix_ff <= hix[PIX_W-1:0];
         loy_ff <= loy[PIX_W-1:0];
         hiy_ff <= hiy[PIX_W-1:0];
         th1_ff <= NUM_W'(abs_area) * NUM_W'(SHADE_LO_MUL);
         th2_ff <= NUM_W'(abs_area) * NUM_W'(SHADE_HI_MUL);
      end
      p_ff    <= p_in;
      tag_ff  <= cmd.mul_op;
      area_ff <= area_in;
      e_ff    <= e_in;
      erow_ff <= erow_in;
      num_ff  <= num_in;
      nrow_ff <= nrow_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      if (cmd.capture) begin
         pend_x_ff    <= px_ff;
         pend_y_ff    <= py_ff;
         pend_band_ff <= band;
      end
      if (cmd.push || cmd.flush) begin
         out_x_ff    <= pend_x_ff;
         out_y_ff    <= pend_y_ff;
         out_band_ff <= pend_band_ff;
         out_last_ff <= cmd.flush;
      end
   end

   always_comb begin : status_out
      status.req_valid  = req_if.valid;
      status.area_zero  = (area_ff == '0);
      status.win_empty  = (lox > hix) || (loy > hiy);
      status.covered    = covered;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
      status.at_last    = (px_ff == hix_ff) && (py_ff == hiy_ff);
   end

endmodule

>>> design/triangle_edge_rasterizer.sv
// Triangle edge-function rasterizer, one 8x8 (TILE_SIZE) tile per transaction.
// req_if: one triangle (three vertices with position and brightness) plus a tile
//   column/row. Taken only while the block is idle (one triangle at a time).
// rsp_if: one transaction per covered pixel of the tile, row by row, left to right,
//   with a 2-bit shade band; last_pixel marks the final pixel of the triangle.
//   Zero area, an empty window or nothing covered gives no transaction at all.
// Sequence: area and setup, then 15 multiplies on the one shared multiplier plus a
//   writeback, before the first pixel is tested. The scan then steps one pixel per
//   cycle with adds unless a full output stalls it, up to TILE_SIZE*TILE_SIZE
//   pixels, then hands off the held pixel.
// Each covered pixel is held until the next one or the scan ends, so last_pixel is
//   known when sent; the rsp output register lets the scan run while a result waits.
// A stalled receiver stalls the scan only when a second covered pixel is found
//   with both the held slot and the output register full.
// Synchronous reset clears the controller and the valid flags; no clearing pass.
module triangle_edge_rasterizer #(
   parameter int CANVAS_WIDTH  = 128,
   parameter int CANVAS_HEIGHT = 128,
   parameter int TILE_SIZE     = 8
) (
   input logic       clock,
   input logic       reset,
   ter_req_if.sink   req_if,
   ter_rsp_if.source rsp_if
);
   import ter_pkg::*;

   ter_cmd_type    cmd;
   ter_status_type status;

   // sequencer: area, setup, multiply sequence, scan, final hand-off
   ter_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // shared multiplier, edge/numerator accumulators, held pixel, output register
   ter_datapath #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT),
      .TILE_SIZE     (TILE_SIZE)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

>>> design/ter_checker.sv
module ter_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ter_pkg::PIX_W-1:0]  rsp_pixel_x,
   input logic [ter_pkg::PIX_W-1:0]  rsp_pixel_y,
   input logic [ter_pkg::BAND_W-1:0] rsp_shade_band,
   input logic                       rsp_last_pixel
);
   import ter_pkg::*;

   // a waiting result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_shade_band) && $stable(rsp_last_pixel))
      else $error("rsp payload changed while stalled");

   // one triangle at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // setup must finish before a new triangle can yield a pixel
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result too soon after request");

   a_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shade_band == BAND_LOW || rsp_shade_band == BAND_MID
         || rsp_shade_band == BAND_HIGH)
      else $error("shade band out of range");

endmodule

bind triangle_edge_rasterizer ter_checker u_ter_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_pixel_x    (rsp_if.pixel_x),
   .rsp_pixel_y    (rsp_if.pixel_y),
   .rsp_shade_band (rsp_if.shade_band),
   .rsp_last_pixel (rsp_if.last_pixel)
);
